### hw/rtl/sppred_pkg.sv
// Package: shared constants, types and state encoding for the shortest-path predecessor core.
package sppred_pkg;

  localparam int unsigned MaxNodesDef   = 64;
  localparam int unsigned WeightBitsDef = 8;
  localparam int unsigned DistBits      = 17;
  localparam int unsigned PredBits      = 7;

  localparam logic [DistBits-1:0] InfDist = 17'd99999;
  localparam logic [PredBits-1:0] NoPred  = 7'h7F;

  localparam logic [1:0] ModeClear = 2'd0;
  localparam logic [1:0] ModeAdd   = 2'd1;
  localparam logic [1:0] ModeQuery = 2'd2;

  localparam logic [2:0] RegNodeCount = 3'd0;

  typedef struct packed {
    logic [DistBits-1:0] path_len;
    logic                fin;
    logic [PredBits-1:0] prev;
  } node_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_ADD_RD,
    ST_ADD_WR,
    ST_INIT,
    ST_SEL,
    ST_FIN,
    ST_RELAX,
    ST_OUT
  } state_e;

endpackage

### hw/rtl/shortest_path_predecessors_core.sv
// Shortest-path predecessor core: edge store, Dijkstra search and predecessor readout.
//
// Usage: requests are taken when start_i is high and busy_o is low. Mode clear
// wipes every entry of the edge store (MaxNodes*MaxNodes entries); the same
// clearing pass runs after reset before the first request is taken. Mode add
// reads the edge, compares and writes back the smaller weight. Mode query
// initializes the n node entries, then per finalized node runs a minimum scan,
// a finalize step and a relaxation scan until the target is finalized or no
// reachable node is left, then reads out n results, where n is the clamped node
// count. The node memory and the edge memory each have one read and one write
// port with a registered read. Results leave one per cycle on node_o,
// predecessor_o and last_node_o while out_valid_o is high; the receiver
// cannot stall them, and each is valid for exactly that cycle. Mode 3 is
// dropped without results. node_count is written over APB at address 0; the
// user must write it only while the core is idle, the core does not enforce it.
module shortest_path_predecessors_core
  import sppred_pkg::*;
#(
  parameter int unsigned MaxNodes   = MaxNodesDef,
  parameter int unsigned WeightBits = WeightBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // APB configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  // request channel
  input  logic                start_i,
  output logic                busy_o,
  input  logic [1:0]          mode_i,
  input  logic [5:0]          from_node_i,
  input  logic [5:0]          to_node_i,
  input  logic [7:0]          weight_i,
  input  logic [5:0]          source_i,
  input  logic [5:0]          target_i,
  // result channel
  output logic                out_valid_o,
  output logic [5:0]          node_o,
  output logic signed [6:0]   predecessor_o,
  output logic                last_node_o
);

  localparam int unsigned IW     = $clog2(MaxNodes);
  localparam int unsigned NW     = $clog2(MaxNodes + 1);
  localparam int unsigned EDepth = MaxNodes * MaxNodes;
  localparam int unsigned EW     = $clog2(EDepth);

  // Configuration register
  logic [6:0] node_count_q;

  assign pready = 1'b1;
  assign prdata = (paddr == RegNodeCount) ? 32'(node_count_q) : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= 7'd64;
    end else if (psel && penable && pwrite && pready && paddr == RegNodeCount) begin
      node_count_q <= pwdata[6:0];
    end
  end

  // Control state
  state_e            state_q, state_d;
  logic [IW-1:0]     cnt_q, cnt_d;
  logic [EW-1:0]     clr_q, clr_d;
  logic              iss_q, iss_d;
  logic              p_vld_q, p_vld_d;
  logic              p_last_q, p_last_d;
  logic [IW-1:0]     p_idx_q, p_idx_d;
  logic [NW-1:0]     n_q, n_d;
  logic [5:0]        src_q, src_d;
  logic [5:0]        tgt_q, tgt_d;
  logic [IW-1:0]     u_q, u_d;
  logic [DistBits-1:0] best_q, best_d;
  logic [PredBits-1:0] bprev_q, bprev_d;
  logic              found_q, found_d;
  logic [EW-1:0]     ea_q, ea_d;
  logic [WeightBits-1:0] aw_q, aw_d;
  logic              out_valid_q, out_valid_d;
  logic [5:0]        node_q, node_d;
  logic [PredBits-1:0] pred_q, pred_d;
  logic              last_q, last_d;

  // Memories
  logic [WeightBits:0] edge_mem [EDepth];
  node_t               node_mem [MaxNodes];

  logic                e_we, n_we;
  logic [EW-1:0]       e_waddr, e_raddr;
  logic [WeightBits:0] e_wdata, e_rdata_q;
  logic [IW-1:0]       n_waddr, n_raddr;
  node_t               n_wdata, n_rdata_q;

  always_ff @(posedge clk_i) begin
    if (e_we) begin
      edge_mem[e_waddr] <= e_wdata;
    end
    e_rdata_q <= edge_mem[e_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (n_we) begin
      node_mem[n_waddr] <= n_wdata;
    end
    n_rdata_q <= node_mem[n_raddr];
  end

  // Helpers
  logic                  accept;
  logic                  add_ok;
  logic [NW-1:0]         n_clamp;
  logic                  scan_last;
  logic                  sel_hit;
  logic [DistBits:0]     cand;
  logic                  relax_hit;
  logic [WeightBits-1:0] e_w;
  logic                  e_present;
  logic                  u_is_tgt;

  assign accept    = start_i && !busy_o;
  assign add_ok    = (32'(from_node_i) < MaxNodes) && (32'(to_node_i) < MaxNodes);
  assign scan_last = (32'(cnt_q) + 32'd1) == 32'(n_q);
  assign e_w       = e_rdata_q[WeightBits-1:0];
  assign e_present = e_rdata_q[WeightBits];
  assign sel_hit   = p_vld_q && !n_rdata_q.fin && (n_rdata_q.path_len < best_q);
  assign cand      = {1'b0, best_q} + (DistBits+1)'(e_w);
  assign relax_hit = p_vld_q && e_present && !n_rdata_q.fin &&
                     ({1'b0, n_rdata_q.path_len} > cand);
  assign u_is_tgt  = 32'(u_q) == 32'(tgt_q);

  always_comb begin
    n_clamp = NW'(node_count_q);
    if (node_count_q == 7'd0) begin
      n_clamp = NW'(1);
    end else if (32'(node_count_q) > MaxNodes) begin
      n_clamp = NW'(MaxNodes);
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (mode_i == ModeClear) begin
            state_d = ST_CLEAR;
          end else if (mode_i == ModeAdd && add_ok) begin
            state_d = ST_ADD_RD;
          end else if (mode_i == ModeQuery) begin
            state_d = ST_INIT;
          end
        end
      end
      ST_CLEAR: begin
        if (32'(clr_q) == EDepth - 1) state_d = ST_IDLE;
      end
      ST_ADD_RD: state_d = ST_ADD_WR;
      ST_ADD_WR: state_d = ST_IDLE;
      ST_INIT: begin
        if (scan_last) state_d = ST_SEL;
      end
      ST_SEL: begin
        if (p_vld_q && p_last_q) state_d = (found_q || sel_hit) ? ST_FIN : ST_OUT;
      end
      ST_FIN: state_d = u_is_tgt ? ST_OUT : ST_RELAX;
      ST_RELAX: begin
        if (p_vld_q && p_last_q) state_d = ST_SEL;
      end
      ST_OUT: begin
        if (p_vld_q && p_last_q) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs and datapath
  always_comb begin
    busy_o      = (state_q != ST_IDLE);
    cnt_d       = cnt_q;
    clr_d       = clr_q;
    iss_d       = iss_q;
    p_vld_d     = 1'b0;
    p_last_d    = 1'b0;
    p_idx_d     = cnt_q;
    n_d         = n_q;
    src_d       = src_q;
    tgt_d       = tgt_q;
    u_d         = u_q;
    best_d      = best_q;
    bprev_d     = bprev_q;
    found_d     = found_q;
    ea_d        = ea_q;
    aw_d        = aw_q;
    out_valid_d = 1'b0;
    node_d      = node_q;
    pred_d      = pred_q;
    last_d      = last_q;
    e_we        = 1'b0;
    e_waddr     = ea_q;
    e_wdata     = '0;
    e_raddr     = EW'(32'(u_q) * MaxNodes + 32'(cnt_q));
    n_we        = 1'b0;
    n_waddr     = cnt_q;
    n_wdata     = '0;
    n_raddr     = cnt_q;

    unique case (state_q)
      ST_IDLE: begin
        e_raddr = EW'(32'(from_node_i) * MaxNodes + 32'(to_node_i));
        ea_d    = e_raddr;
        aw_d    = WeightBits'(weight_i);
        clr_d   = '0;
        cnt_d   = '0;
        n_d     = n_clamp;
        src_d   = source_i;
        tgt_d   = target_i;
      end
      ST_CLEAR: begin
        e_we    = 1'b1;
        e_waddr = clr_q;
        clr_d   = clr_q + EW'(1);
      end
      ST_ADD_RD: begin
        e_raddr = ea_q;
      end
      ST_ADD_WR: begin
        // keep the smaller weight of a repeated edge
        e_we    = 1'b1;
        e_wdata = {1'b1, (e_present && e_w <= aw_q) ? e_w : aw_q};
      end
      ST_INIT: begin
        n_we             = 1'b1;
        n_wdata.path_len = (32'(cnt_q) == 32'(src_q) && 32'(src_q) < 32'(n_q)) ?
                           '0 : InfDist;
        n_wdata.fin      = 1'b0;
        n_wdata.prev     = NoPred;
        cnt_d            = scan_last ? '0 : cnt_q + IW'(1);
        iss_d            = scan_last;
        best_d           = InfDist;
        found_d          = 1'b0;
      end
      ST_SEL, ST_RELAX, ST_OUT: begin
        if (iss_q) begin
          p_vld_d  = 1'b1;
          p_last_d = scan_last;
          iss_d    = !scan_last;
          cnt_d    = scan_last ? cnt_q : cnt_q + IW'(1);
        end
        if (state_q == ST_SEL && sel_hit) begin
          best_d  = n_rdata_q.path_len;
          bprev_d = n_rdata_q.prev;
          u_d     = p_idx_q;
          found_d = 1'b1;
        end
        if (state_q == ST_RELAX && relax_hit) begin
          n_we             = 1'b1;
          n_waddr          = p_idx_q;
          n_wdata.path_len = cand[DistBits-1:0];
          n_wdata.fin      = 1'b0;
          n_wdata.prev     = PredBits'(u_q);
        end
        if (state_q == ST_OUT && p_vld_q) begin
          out_valid_d = 1'b1;
          node_d      = 6'(p_idx_q);
          pred_d      = n_rdata_q.prev;
          last_d      = p_last_q;
        end
        if (p_vld_q && p_last_q) begin
          // restart the scan for the next phase; hold the winner after a minimum scan
          cnt_d = '0;
          iss_d = 1'b1;
          if (state_q != ST_SEL) begin
            best_d  = InfDist;
            found_d = 1'b0;
          end
        end
      end
      ST_FIN: begin
        n_we             = 1'b1;
        n_waddr          = u_q;
        n_wdata.path_len = best_q;
        n_wdata.fin      = 1'b1;
        n_wdata.prev     = bprev_q;
        cnt_d            = '0;
        iss_d            = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      cnt_q       <= '0;
      iss_q       <= 1'b0;
      p_vld_q     <= 1'b0;
      p_last_q    <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      cnt_q       <= cnt_d;
      iss_q       <= iss_d;
      p_vld_q     <= p_vld_d;
      p_last_q    <= p_last_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_idx_q <= p_idx_d;
    n_q     <= n_d;
    src_q   <= src_d;
    tgt_q   <= tgt_d;
    u_q     <= u_d;
    best_q  <= best_d;
    bprev_q <= bprev_d;
    ea_q    <= ea_d;
    aw_q    <= aw_d;
    node_q  <= node_d;
    pred_q  <= pred_d;
    last_q  <= last_d;
  end

  assign out_valid_o   = out_valid_q;
  assign node_o        = node_q;
  assign predecessor_o = pred_q;
  assign last_node_o   = last_q;

  // Checks
  a_out_from_readout: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $past(state_q == ST_OUT))
    else $error("result strobe outside readout");

  a_fin_reached: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FIN |-> best_q < InfDist)
    else $error("finalizing an unreached node");

  a_relax_lowers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RELAX && n_we) |-> cand < {1'b0, InfDist})
    else $error("relaxation wrote a distance at or above infinity");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_node_o) |=> !out_valid_o)
    else $error("result after last node");

endmodule
